>>> rtl/brf_pkg.sv
// shared types and constants for the byte ring fifo
package brf_pkg;

  localparam int BYTE_W  = 8;
  localparam int SIZE_W  = 4;
  localparam int REQ_W   = 7;
  localparam int LEVEL_W = 9;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

  // command codes
  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  // one result transaction
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               has_data;
    logic               accepted;
    logic               last;
    logic [LEVEL_W-1:0] level;
  } result_t;

endpackage

>>> rtl/brf_ram.sv
// generic simple dual port ram with registered read
module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/byte_ring_fifo_top.sv
// byte fifo over a power-of-two ring store, top level
//
// Input channel (in_valid / in_stall) carries command, data_byte and
// read_count. A put stores data_byte if there is room and gives one result;
// a get gives min(read_count, MAX_BURST, level) results, one byte each, the final one
// marked with last. A get on an empty queue, or with read_count zero,
// gives a single marked result without data. Every result carries level.
// Output channel (out_valid / out_stall) carries the results through a
// two-entry output queue, so the receiver may stall at any time.
// Config channel (cfg_valid / cfg_ready) writes size_log2 and empties the queue;
// it is ready outside reset. The user must write it only while the block is idle;
// the block does not enforce this. A result is held in the pending register,
// then in the output queue. Throughput: one item per cycle for puts, and one
// byte per cycle during a get burst, set by the single registered read port of
// the ring store; a new item is taken the cycle after a burst's last read. A
// stalled receiver holds the queue full and then blocks input.
// Reset stalls the input, empties the queue and sets size_log2 to 8; the ring
// store itself is not cleared, only entries written since the last emptying are read.
module byte_ring_fifo_top #(
  parameter int MAX_DEPTH = 256,
  parameter int MAX_BURST = 64
) (
  input  logic                         clk,
  input  logic                         rst,
  // input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         command,
  input  logic [brf_pkg::BYTE_W-1:0]   data_byte,
  input  logic [brf_pkg::REQ_W-1:0]    read_count,
  // output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [brf_pkg::BYTE_W-1:0]   out_byte,
  output logic                         has_data,
  output logic                         accepted,
  output logic                         last,
  output logic [brf_pkg::LEVEL_W-1:0]  level,
  // config channel
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [brf_pkg::SIZE_W-1:0]   cfg_data
);

  localparam int AW   = $clog2(MAX_DEPTH);
  localparam int CW   = AW + 1;
  localparam int LG_W = 5;
  localparam int EW   = (CW > brf_pkg::LEVEL_W) ? CW : brf_pkg::LEVEL_W;
  localparam int NW   = (CW > brf_pkg::REQ_W) ? CW : brf_pkg::REQ_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_GET  = 1'b1;

  logic                        state;
  logic [brf_pkg::SIZE_W-1:0]  size_log2;
  logic [CW-1:0]               wr_cnt;
  logic [CW-1:0]               rd_cnt;
  logic [brf_pkg::REQ_W-1:0]   remain;

  // pending result waiting for ram read data
  logic                        pend_valid;
  logic                        pend_rd;
  logic                        pend_acc;
  logic                        pend_last;
  logic [brf_pkg::LEVEL_W-1:0] pend_level;

  // output queue
  brf_pkg::result_t            q [2];
  logic [1:0]                  q_cnt;

  logic [brf_pkg::BYTE_W-1:0]  rd_data;
  brf_pkg::result_t            pend_res;

  logic [LG_W-1:0]             lg_min;
  logic [LG_W-1:0]             lg_eff;
  logic [CW-1:0]               cap;
  logic [AW-1:0]               addr_mask;
  logic [CW-1:0]               occ;
  logic                        full;
  logic [brf_pkg::REQ_W-1:0]   want;
  logic [NW-1:0]               want_ext;
  logic [NW-1:0]               occ_ext;
  logic [NW-1:0]               n_ext;
  logic [brf_pkg::REQ_W-1:0]   n;

  logic                        pop;
  logic [1:0]                  cnt_after;
  logic [1:0]                  q_cnt_next;
  logic                        room;
  logic                        in_fire;
  logic                        put_fire;
  logic                        get_fire;
  logic                        store;
  logic                        issue;
  logic                        launch;
  logic                        cfg_fire;
  logic                        l_next;
  logic [EW-1:0]               lvl_ext;
  logic [CW-1:0]               lvl_next;

  // capacity and occupancy
  always_comb begin
    lg_min    = (size_log2 == '0) ? LG_W'(1) : LG_W'(size_log2);
    lg_eff    = (lg_min > LG_W'(AW)) ? LG_W'(AW) : lg_min;
    cap       = CW'(1) << lg_eff;
    addr_mask = AW'(cap - CW'(1));
    occ       = wr_cnt - rd_cnt;
    full      = occ >= cap;
  end

  // burst length of a get
  always_comb begin
    want     = (read_count > brf_pkg::REQ_W'(MAX_BURST)) ?
               brf_pkg::REQ_W'(MAX_BURST) : read_count;
    want_ext = NW'(want);
    occ_ext  = NW'(occ);
    n_ext    = (want_ext < occ_ext) ? want_ext : occ_ext;
    n        = n_ext[brf_pkg::REQ_W-1:0];
  end

  // handshakes and room in the output queue
  always_comb begin
    pop        = (q_cnt != 2'd0) && !out_stall;
    cnt_after  = q_cnt - {1'b0, pop};
    q_cnt_next = cnt_after + {1'b0, pend_valid};
    room       = q_cnt_next < 2'd2;
    in_stall   = rst || !((state == ST_IDLE) && room);
    in_fire    = in_valid && !in_stall;
    put_fire   = in_fire && (command == brf_pkg::CMD_PUT);
    get_fire   = in_fire && (command == brf_pkg::CMD_GET);
    store      = put_fire && !full;
    issue      = (get_fire && (n != '0)) || ((state == ST_GET) && room);
    launch     = in_fire || ((state == ST_GET) && room);
    cfg_ready  = !rst;
    cfg_fire   = cfg_valid && cfg_ready;
  end

  // fields of the next pending result
  always_comb begin
    l_next   = 1'b1;
    lvl_next = occ;
    if (store) begin
      lvl_next = occ + CW'(1);
    end else if (issue) begin
      lvl_next = occ - CW'(1);
      l_next   = (state == ST_GET) ? (remain == brf_pkg::REQ_W'(1))
                                   : (n == brf_pkg::REQ_W'(1));
    end
    lvl_ext = EW'(lvl_next);
  end

  // control state and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      size_log2  <= brf_pkg::SIZE_RESET;
      wr_cnt     <= '0;
      rd_cnt     <= '0;
      remain     <= '0;
      pend_valid <= 1'b0;
    end else begin
      pend_valid <= launch;
      if (store) begin
        wr_cnt <= wr_cnt + CW'(1);
      end
      if (issue) begin
        rd_cnt <= rd_cnt + CW'(1);
      end
      if (get_fire && (n > brf_pkg::REQ_W'(1))) begin
        state  <= ST_GET;
        remain <= n - brf_pkg::REQ_W'(1);
      end else if ((state == ST_GET) && room) begin
        remain <= remain - brf_pkg::REQ_W'(1);
        if (remain == brf_pkg::REQ_W'(1)) begin
          state <= ST_IDLE;
        end
      end
      if (cfg_fire) begin
        size_log2 <= cfg_data;
        wr_cnt    <= '0;
        rd_cnt    <= '0;
      end
    end
  end

  // pending result payload
  always_ff @(posedge clk) begin
    if (launch) begin
      pend_rd    <= issue;
      pend_acc   <= store;
      pend_last  <= l_next;
      pend_level <= lvl_ext[brf_pkg::LEVEL_W-1:0];
    end
  end

  // ring store
  brf_ram #(
    .WIDTH (brf_pkg::BYTE_W),
    .DEPTH (MAX_DEPTH)
  ) u_ring (
    .clk     (clk),
    .wr_en   (store),
    .wr_addr (wr_cnt[AW-1:0] & addr_mask),
    .wr_data (data_byte),
    .rd_en   (issue),
    .rd_addr (rd_cnt[AW-1:0] & addr_mask),
    .rd_data (rd_data)
  );

  // assemble the result once read data is back
  always_comb begin
    pend_res.out_byte = pend_rd ? rd_data : '0;
    pend_res.has_data = pend_rd;
    pend_res.accepted = pend_acc;
    pend_res.last     = pend_last;
    pend_res.level    = pend_level;
  end

  // output queue count
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt <= 2'd0;
    end else begin
      q_cnt <= q_cnt_next;
    end
  end

  // output queue payload, head in entry 0
  always_ff @(posedge clk) begin
    if (pend_valid && (cnt_after == 2'd0)) begin
      q[0] <= pend_res;
    end else if (pop) begin
      q[0] <= q[1];
    end
    if (pend_valid && (cnt_after != 2'd0)) begin
      q[1] <= pend_res;
    end
  end

  // output ports
  assign out_valid = q_cnt != 2'd0;
  assign out_byte  = q[0].out_byte;
  assign has_data  = q[0].has_data;
  assign accepted  = q[0].accepted;
  assign last      = q[0].last;
  assign level     = q[0].level;

  // a pending result always finds a free queue entry
  assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (q_cnt != 2'd2) || pop)
    else $error("output queue overflow");

  // queue count never goes past two
  assert property (@(posedge clk) disable iff (rst)
    q_cnt != 2'd3)
    else $error("output queue count out of range");

  // a burst never reads an empty queue
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_GET) |-> (occ != '0) && (remain != '0))
    else $error("burst read past the stored bytes");

  // a put on a full queue leaves the write counter alone
  assert property (@(posedge clk) disable iff (rst)
    (put_fire && full && !cfg_fire) |=> $stable(wr_cnt))
    else $error("write counter moved on a full put");

  // no input is taken during a burst
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_GET) |-> in_stall)
    else $error("input taken during a burst");

endmodule

>>> test/byte_ring_fifo_top_tb.sv
// self-checking testbench for the byte ring fifo top level
`timescale 1ns / 100ps

module byte_ring_fifo_top_tb;

  localparam int FIFO_DEPTH   = 256;
  localparam int BURST_MAX    = 64;
  localparam int HOLD_CYCLES  = 150;
  localparam int SETTLE_GAP   = 4;
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int REPORT_LIMIT = 10;
  localparam logic [brf_pkg::SIZE_W-1:0] FILL_LG = 4'd4;

  typedef enum logic {ROW_ITEM, ROW_SIZE} row_kind_t;

  // one row of the directed table
  typedef struct {
    row_kind_t                   kind;
    logic                        cmd;
    logic [brf_pkg::BYTE_W-1:0]  data;
    logic [brf_pkg::REQ_W-1:0]   count;
    logic [brf_pkg::SIZE_W-1:0]  size_lg;
    bit                          typed_res;
    brf_pkg::result_t            want;
  } stim_row_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic                         command = brf_pkg::CMD_PUT;
  logic [brf_pkg::BYTE_W-1:0]   data_byte = '0;
  logic [brf_pkg::REQ_W-1:0]    read_count = 7'd1;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic [brf_pkg::BYTE_W-1:0]   out_byte;
  logic                         has_data;
  logic                         accepted;
  logic                         last;
  logic [brf_pkg::LEVEL_W-1:0]  level;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [brf_pkg::SIZE_W-1:0]   cfg_data = '0;

  // fifo predictor state
  logic [brf_pkg::BYTE_W-1:0]   model_ring [FIFO_DEPTH];
  logic [brf_pkg::LEVEL_W-1:0]  model_wr;
  logic [brf_pkg::LEVEL_W-1:0]  model_rd;
  logic [brf_pkg::SIZE_W-1:0]   model_size_lg;

  brf_pkg::result_t             step_results [$];
  brf_pkg::result_t             pending_results [$];
  stim_row_t                    directed_rows [$];

  int                  mismatch_count = 0;
  int unsigned         cycle_count = 0;
  logic                idle_on = 1'b1;
  int                  hold_trigger = 0;
  int                  hold_seen = 0;
  int                  hold_left = 0;
  int                  stall_left = 0;

  byte_ring_fifo_top #(
    .MAX_DEPTH(FIFO_DEPTH),
    .MAX_BURST(BURST_MAX)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .command    (command),
    .data_byte  (data_byte),
    .read_count (read_count),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .has_data   (has_data),
    .accepted   (accepted),
    .last       (last),
    .level      (level),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic brf_pkg::result_t mk_res(logic [brf_pkg::BYTE_W-1:0] b, logic has,
                                              logic acc, logic lst,
                                              logic [brf_pkg::LEVEL_W-1:0] lvl);
    brf_pkg::result_t r;
    r.out_byte = b;
    r.has_data = has;
    r.accepted = acc;
    r.last     = lst;
    r.level    = lvl;
    return r;
  endfunction

  function automatic stim_row_t item_row(logic cmd, logic [brf_pkg::BYTE_W-1:0] d,
                                         logic [brf_pkg::REQ_W-1:0] n,
                                         bit typed_res, brf_pkg::result_t want);
    stim_row_t row;
    row.kind      = ROW_ITEM;
    row.cmd       = cmd;
    row.data      = d;
    row.count     = n;
    row.size_lg   = '0;
    row.typed_res = typed_res;
    row.want      = want;
    return row;
  endfunction

  function automatic stim_row_t size_row(logic [brf_pkg::SIZE_W-1:0] lg);
    stim_row_t row;
    row.kind      = ROW_SIZE;
    row.cmd       = brf_pkg::CMD_PUT;
    row.data      = '0;
    row.count     = '0;
    row.size_lg   = lg;
    row.typed_res = 1'b0;
    row.want      = '0;
    return row;
  endfunction

  // capacity in use: size 0 acts as 1, oversize clamps to the store depth
  function automatic int ring_capacity();
    int lg;
    int cap;
    lg = model_size_lg;
    if (lg < 1) lg = 1;
    cap = 1 << lg;
    if (cap > FIFO_DEPTH) cap = FIFO_DEPTH;
    return cap;
  endfunction

  // predicted results of one accepted transaction, left in step_results
  task automatic predict_fifo_step(input logic cmd, input logic [brf_pkg::BYTE_W-1:0] d,
                                   input logic [brf_pkg::REQ_W-1:0] n);
    int                          cap;
    logic [brf_pkg::BYTE_W-1:0]  mask;
    logic [brf_pkg::LEVEL_W-1:0] occ;
    int                          want;
    int                          take;
    int                          i;
    logic [brf_pkg::BYTE_W-1:0]  b;
    cap  = ring_capacity();
    mask = brf_pkg::BYTE_W'(cap - 1);
    occ  = model_wr - model_rd;
    step_results.delete();
    if (cmd == brf_pkg::CMD_PUT) begin
      if (occ >= cap) begin
        step_results.push_back(mk_res('0, 1'b0, 1'b0, 1'b1, occ));
      end else begin
        model_ring[model_wr[brf_pkg::BYTE_W-1:0] & mask] = d;
        model_wr = model_wr + 1'b1;
        step_results.push_back(mk_res('0, 1'b0, 1'b1, 1'b1, model_wr - model_rd));
      end
    end else begin
      want = (n > BURST_MAX) ? BURST_MAX : n;
      take = (want < occ) ? want : occ;
      if (take == 0) begin
        step_results.push_back(mk_res('0, 1'b0, 1'b0, 1'b1, occ));
      end else begin
        for (i = 0; i < take; i++) begin
          b = model_ring[model_rd[brf_pkg::BYTE_W-1:0] & mask];
          model_rd = model_rd + 1'b1;
          step_results.push_back(mk_res(b, 1'b1, 1'b0, i == take - 1, model_wr - model_rd));
        end
      end
    end
  endtask

  // offer one transaction, with an optional idle gap in front
  task automatic send_item(input logic cmd, input logic [brf_pkg::BYTE_W-1:0] d,
                           input logic [brf_pkg::REQ_W-1:0] n, input bit typed_res,
                           input brf_pkg::result_t typed_want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    data_byte  <= d;
    read_count <= n;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_fifo_step(cmd, d, n);
    if (typed_res) pending_results.push_back(typed_want);
    else foreach (step_results[k]) pending_results.push_back(step_results[k]);
  endtask

  // stop offering and let every expected result come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  // size register write, only once the block is idle
  task automatic write_size(input logic [brf_pkg::SIZE_W-1:0] lg);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= lg;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    model_size_lg = lg;
    model_wr      = '0;
    model_rd      = '0;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // random mix of puts and gets, optionally pausing half way until drained
  task automatic run_random(input int count, input bit mid_drain);
    int                          j;
    int                          pick;
    logic [brf_pkg::REQ_W-1:0]   n;
    for (j = 0; j < count; j++) begin
      if (mid_drain && j == count / 2) wait_idle();
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_item(brf_pkg::CMD_PUT, brf_pkg::BYTE_W'($urandom_range(0, 255)),
                  brf_pkg::REQ_W'($urandom_range(0, 127)), 1'b0, '0);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 10) n = '0;
        else if (pick < 25) n = brf_pkg::REQ_W'($urandom_range(9, 127));
        else n = brf_pkg::REQ_W'($urandom_range(1, 8));
        send_item(brf_pkg::CMD_GET, brf_pkg::BYTE_W'($urandom_range(0, 255)), n,
                  1'b0, '0);
      end
    end
  endtask

  // receiver stall: long hold on request, else random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      stall_left <= 0;
    end else if (hold_seen != hold_trigger) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 10);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin : result_check
    brf_pkg::result_t got;
    brf_pkg::result_t want;
    if (!rst && out_valid && !out_stall) begin
      got = {out_byte, has_data, accepted, last, level};
      if (pending_results.size() == 0) begin
        if (mismatch_count < REPORT_LIMIT)
          $display("unexpected result: byte %h has %b acc %b last %b level %0d",
                   got.out_byte, got.has_data, got.accepted, got.last, got.level);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.out_byte !== want.out_byte || got.has_data !== want.has_data ||
            got.accepted !== want.accepted || got.last !== want.last ||
            got.level !== want.level) begin
          if (mismatch_count < REPORT_LIMIT)
            $display("mismatch: exp byte %h has %b acc %b last %b level %0d,",
                     want.out_byte, want.has_data, want.accepted, want.last, want.level,
                     " got byte %h has %b acc %b last %b level %0d",
                     got.out_byte, got.has_data, got.accepted, got.last, got.level);
          mismatch_count++;
        end
      end
    end
  end

  // stimulus sequence
  initial begin
    int k;
    model_wr      = '0;
    model_rd      = '0;
    model_size_lg = brf_pkg::SIZE_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset, capacity 256
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'h00, 7'd5, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b0, 1'b1, 9'd0)));
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'hFF, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b0, 1'b1, 9'd0)));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'h00, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b1, 1'b1, 9'd1)));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'hFF, 7'd127, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b1, 1'b1, 9'd2)));
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'h00, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b0, 1'b1, 9'd2)));
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'h00, 7'd1, 1'b0, '0));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'hA5, 7'd1, 1'b0, '0));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'h5A, 7'd1, 1'b0, '0));
    // burst request above the limit saturates
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'h00, 7'd127, 1'b0, '0));
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'h00, 7'd64, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b0, 1'b1, 9'd0)));
    // smallest capacity, put when full
    directed_rows.push_back(size_row(4'd1));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'h11, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b1, 1'b1, 9'd1)));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'h22, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b1, 1'b1, 9'd2)));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'h33, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b0, 1'b1, 9'd2)));
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'h00, 7'd64, 1'b0, '0));
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'h00, 7'd1, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b0, 1'b1, 9'd0)));
    // size zero acts as one
    directed_rows.push_back(size_row(4'd0));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'hC3, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b1, 1'b1, 9'd1)));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'h3C, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b1, 1'b1, 9'd2)));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'h99, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b0, 1'b1, 9'd2)));
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'h00, 7'd2, 1'b0, '0));
    // oversize clamps to the store depth
    directed_rows.push_back(size_row(4'd15));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'h80, 7'd0, 1'b1,
                                     mk_res(8'h00, 1'b0, 1'b1, 1'b1, 9'd1)));
    directed_rows.push_back(item_row(brf_pkg::CMD_PUT, 8'h01, 7'd0, 1'b0, '0));
    directed_rows.push_back(item_row(brf_pkg::CMD_GET, 8'h00, 7'd2, 1'b0, '0));

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_SIZE)
        write_size(directed_rows[k].size_lg);
      else
        send_item(directed_rows[k].cmd, directed_rows[k].data, directed_rows[k].count,
                  directed_rows[k].typed_res, directed_rows[k].want);
    end

    // random phases over several sizes
    write_size(4'd2);
    run_random(12, 1'b0);
    write_size(4'd5);
    run_random(16, 1'b1);

    // fill a small store while the receiver holds off, then drain in one burst
    write_size(FILL_LG);
    hold_trigger <= hold_trigger + 1;
    for (k = 0; k < (1 << FILL_LG) + 4; k++)
      send_item(brf_pkg::CMD_PUT, brf_pkg::BYTE_W'($urandom_range(0, 255)),
                brf_pkg::REQ_W'($urandom_range(0, 127)), 1'b0, '0);
    send_item(brf_pkg::CMD_GET, brf_pkg::BYTE_W'($urandom_range(0, 255)),
              brf_pkg::REQ_W'(BURST_MAX), 1'b0, '0);

    write_size(4'd1);
    run_random(8, 1'b0);
    write_size(4'd12);
    run_random(8, 1'b0);

    // last part runs without idling
    write_size(4'd3);
    idle_on <= 1'b0;
    @(posedge clk);
    run_random(12, 1'b0);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> byte_ring_fifo_top.f
rtl/brf_pkg.sv
rtl/brf_ram.sv
rtl/byte_ring_fifo_top.sv
test/byte_ring_fifo_top_tb.sv
